### src/two_point_basis_coordinates_assert.svh
// ----------------------------------------------------------------------------
// Two-point basis coordinates: assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_BASIS_COORDINATES_ASSERT_SVH
`define TWO_POINT_BASIS_COORDINATES_ASSERT_SVH

// same-cycle implication
`define TPBC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define TPBC_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### src/tpbc_pkg.sv
// ----------------------------------------------------------------------------
// tpbc_pkg
// Widths, formats and shared types of the two-point basis coordinate block.
// ----------------------------------------------------------------------------
package tpbc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 32;
  localparam int DIFF_W = IN_W + 1;
  localparam int CEN_W  = IN_W + 2;
  localparam int NUM_W  = DIFF_W + CEN_W;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = 2 * DIFF_W - 1;
  localparam int DIV_W  = DEN_W + 1;
  localparam int Q_W    = OUT_W + 1;
  localparam int NW     = MAG_W + FRAC_BITS + 2;
  localparam int NH_W   = NW - Q_W;
  localparam int CMP_W  = (NH_W > DIV_W) ? NH_W : DIV_W;

  localparam int DIV_LAT = Q_W + 4;
  localparam int LATENCY = DIV_LAT + 4;

  localparam logic [Q_W-1:0]   POS_MAX = (Q_W'(1) << (OUT_W - 1)) - Q_W'(1);
  localparam logic [Q_W-1:0]   NEG_MAX = Q_W'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] POS_VAL = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_VAL = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic tag;
  } tpbc_ctl_t;

endpackage

### src/tpbc_div.sv
// ----------------------------------------------------------------------------
// tpbc_div
// Pipelined fixed-point divider: signed numerator over positive denominator,
// rounded to nearest with ties away from zero, saturated to the output width.
// One quotient bit per stage; a new item may enter every cycle.
// ----------------------------------------------------------------------------
module tpbc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tpbc_pkg::tpbc_ctl_t                 in_ctl,
  input  logic signed [tpbc_pkg::NUM_W-1:0]   in_num,
  input  logic        [tpbc_pkg::DEN_W-1:0]   in_den,
  output tpbc_pkg::tpbc_ctl_t                 out_ctl,
  output logic signed [tpbc_pkg::OUT_W-1:0]   out_value,
  output logic                                out_clip
);
  import tpbc_pkg::*;

  // magnitude stage
  logic             valid_a_r, tag_a_r, neg_a_r;
  logic [MAG_W-1:0] mag_a_r;
  logic [DEN_W-1:0] den_a_r;
  logic [NUM_W-1:0] mag_nxt;

  always_comb begin
    mag_nxt = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_a_r <= in_ctl.tag;
    neg_a_r <= in_num[NUM_W-1];
    mag_a_r <= mag_nxt[MAG_W-1:0];
    den_a_r <= in_den;
  end

  // scaled, rounding-biased numerator and doubled divisor
  logic             valid_b_r, tag_b_r, neg_b_r;
  logic [NW-1:0]    n_b_r;
  logic [DIV_W-1:0] d_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_b_r <= tag_a_r;
    neg_b_r <= neg_a_r;
    n_b_r   <= (NW'(mag_a_r) << (FRAC_BITS + 1)) + NW'(den_a_r);
    d_b_r   <= {den_a_r, 1'b0};
  end

  // overflow check on the high part, then one quotient bit per stage
  logic             valid_r [Q_W+1];
  logic             tag_r   [Q_W+1];
  logic             neg_r   [Q_W+1];
  logic             ovf_r   [Q_W+1];
  logic [DIV_W-1:0] d_r     [Q_W+1];
  logic [DIV_W-1:0] rem_r   [Q_W+1];
  logic [Q_W-1:0]   rq_r    [Q_W+1];
  logic [NH_W-1:0]  nh;

  assign nh = n_b_r[NW-1:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= tag_b_r;
    neg_r[0] <= neg_b_r;
    ovf_r[0] <= CMP_W'(nh) >= CMP_W'(d_b_r);
    d_r[0]   <= d_b_r;
    rem_r[0] <= DIV_W'(nh);
    rq_r[0]  <= n_b_r[Q_W-1:0];
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem_r[k], rq_r[k][Q_W-1]};
      diff  = trial - {1'b0, d_r[k]};
      ge    = trial >= {1'b0, d_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[k+1] <= tag_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
      d_r[k+1]   <= d_r[k];
      rem_r[k+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      rq_r[k+1]  <= {rq_r[k][Q_W-2:0], ge};
    end
  end

  // sign and clip
  logic [Q_W-1:0]   q, nq;
  logic             pos_sat, neg_sat;
  logic [OUT_W-1:0] value_nxt;
  logic             clip_nxt;
  logic             valid_o_r, tag_o_r, clip_o_r;
  logic [OUT_W-1:0] value_o_r;

  always_comb begin
    q       = rq_r[Q_W];
    nq      = Q_W'(0) - q;
    pos_sat = ovf_r[Q_W] || (q > POS_MAX);
    neg_sat = ovf_r[Q_W] || (q > NEG_MAX);
    if (neg_r[Q_W]) begin
      value_nxt = neg_sat ? NEG_VAL : nq[OUT_W-1:0];
      clip_nxt  = neg_sat;
    end else begin
      value_nxt = pos_sat ? POS_VAL : q[OUT_W-1:0];
      clip_nxt  = pos_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o_r <= 1'b0;
    end else begin
      valid_o_r <= valid_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    tag_o_r   <= tag_r[Q_W];
    value_o_r <= value_nxt;
    clip_o_r  <= clip_nxt;
  end

  assign out_ctl.valid = valid_o_r;
  assign out_ctl.tag   = tag_o_r;
  assign out_value     = $signed(value_o_r);
  assign out_clip      = clip_o_r;

endmodule

### src/two_point_basis_coordinates.sv
// ----------------------------------------------------------------------------
// two_point_basis_coordinates
// Maps a query point into the similarity-invariant frame of two basis points.
// ----------------------------------------------------------------------------
// Results pass through the input, product and sum registers, the bit-per-stage
//   divider (one stage for each of 33 quotient bits) and the result register.
// Throughput: one item per cycle; busy is low out of reset and nothing stalls.
// Results come as one-cycle strobes that the receiver must take.
// Reset (rst_n low, synchronous) holds busy high and clears all valid bits;
//   items in flight are dropped.
// ----------------------------------------------------------------------------
module two_point_basis_coordinates (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tpbc_pkg::IN_W-1:0]   in_first_x,
  input  logic signed [tpbc_pkg::IN_W-1:0]   in_first_y,
  input  logic signed [tpbc_pkg::IN_W-1:0]   in_second_x,
  input  logic signed [tpbc_pkg::IN_W-1:0]   in_second_y,
  input  logic signed [tpbc_pkg::IN_W-1:0]   in_query_x,
  input  logic signed [tpbc_pkg::IN_W-1:0]   in_query_y,
  output logic                               out_valid,
  output logic signed [tpbc_pkg::OUT_W-1:0]  out_coord_u,
  output logic signed [tpbc_pkg::OUT_W-1:0]  out_coord_v,
  output logic                               out_degenerate,
  output logic                               out_saturated
);
  import tpbc_pkg::*;

  `include "two_point_basis_coordinates_assert.svh"

  assign busy = !rst_n;

  // basis difference and doubled query offset
  logic                     v2_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [CEN_W-1:0]  qx_r, qy_r, qx_nxt, qy_nxt;

  always_comb begin
    dx_nxt = DIFF_W'(in_second_x) - DIFF_W'(in_first_x);
    dy_nxt = DIFF_W'(in_second_y) - DIFF_W'(in_first_y);
    qx_nxt = CEN_W'(in_query_x) + CEN_W'(in_query_x)
           - CEN_W'(in_first_x) - CEN_W'(in_second_x);
    qy_nxt = CEN_W'(in_query_y) + CEN_W'(in_query_y)
           - CEN_W'(in_first_y) - CEN_W'(in_second_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
  end

  // products
  logic                    v3_r, degen3_r;
  logic signed [NUM_W-1:0] sxx_r, syy_r, xu_r, yu_r, xv_r, yv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    degen3_r <= (dx_r == '0) && (dy_r == '0);
    sxx_r    <= NUM_W'(dx_r) * NUM_W'(dx_r);
    syy_r    <= NUM_W'(dy_r) * NUM_W'(dy_r);
    xu_r     <= NUM_W'(dx_r) * NUM_W'(qx_r);
    yu_r     <= NUM_W'(dy_r) * NUM_W'(qy_r);
    xv_r     <= NUM_W'(dx_r) * NUM_W'(qy_r);
    yv_r     <= NUM_W'(dy_r) * NUM_W'(qx_r);
  end

  // sums
  logic                    v4_r, degen4_r;
  logic        [DEN_W-1:0] den_r;
  logic signed [NUM_W-1:0] nu_r, nv_r, den_nxt;

  assign den_nxt = sxx_r + syy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    degen4_r <= degen3_r;
    den_r    <= den_nxt[DEN_W-1:0];
    nu_r     <= xu_r + yu_r;
    nv_r     <= xv_r - yv_r;
  end

  // dividers
  tpbc_ctl_t               div_in_ctl, u_ctl, v_ctl, v_in_ctl;
  logic signed [OUT_W-1:0] u_value, v_value;
  logic                    u_clip, v_clip;

  assign div_in_ctl.valid = v4_r;
  assign div_in_ctl.tag   = degen4_r;
  assign v_in_ctl.valid   = v4_r;
  assign v_in_ctl.tag     = 1'b0;

  tpbc_div u_div_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (div_in_ctl),
    .in_num    (nu_r),
    .in_den    (den_r),
    .out_ctl   (u_ctl),
    .out_value (u_value),
    .out_clip  (u_clip)
  );

  tpbc_div u_div_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (v_in_ctl),
    .in_num    (nv_r),
    .in_den    (den_r),
    .out_ctl   (v_ctl),
    .out_value (v_value),
    .out_clip  (v_clip)
  );

  // result register; force zeros for coincident basis points
  logic                    out_valid_r, out_degen_r, out_sat_r;
  logic signed [OUT_W-1:0] out_u_r, out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= u_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_degen_r <= u_ctl.tag;
    out_sat_r   <= !u_ctl.tag && (u_clip || v_clip);
    out_u_r     <= u_ctl.tag ? '0 : u_value;
    out_v_r     <= u_ctl.tag ? '0 : v_value;
  end

  assign out_valid      = out_valid_r;
  assign out_coord_u    = out_u_r;
  assign out_coord_v    = out_v_r;
  assign out_degenerate = out_degen_r;
  assign out_saturated  = out_sat_r;

  `TPBC_ASSERT_DELAY(a_result_follows, start && !busy, LATENCY, out_valid, "item lost in pipeline")
  `TPBC_ASSERT_IMPL(a_no_stray_result, out_valid, $past(start && !busy, LATENCY), "stray result")
  `TPBC_ASSERT_IMPL(a_div_lockstep, u_ctl.valid || v_ctl.valid, u_ctl.valid && v_ctl.valid, "dividers out of step")
  `TPBC_ASSERT_IMPL(a_degen_zero, out_valid && out_degenerate, out_coord_u == '0 && out_coord_v == '0 && !out_saturated, "degenerate result not cleared")

endmodule
